// File: sv/fpba_pkg.sv
package fpba_pkg;

  localparam int ArenaBytes  = 1024;
  localparam int HeaderBytes = 16;
  localparam int MaxBlocks   = 16;

  localparam int AW = 10;                  // byte offsets and sizes
  localparam int IW = $clog2(MaxBlocks);   // table index
  localparam int CW = IW + 1;              // block count

  localparam logic [AW-1:0] HDR      = AW'(HeaderBytes);
  localparam logic [AW-1:0] ROOT_SZ  = AW'(ArenaBytes - HeaderBytes);
  localparam logic [CW-1:0] FULL_CNT = CW'(MaxBlocks);

  typedef enum logic [1:0] {
    POL_FIRST = 2'd0,
    POL_NEXT  = 2'd1,
    POL_BEST  = 2'd2,
    POL_WORST = 2'd3
  } policy_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NOFIT  = 2'd1,
    ST_BADREL = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  localparam logic FUNC_ALLOC   = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_SPLIT_SHIFT,
    S_REL_NEXT,
    S_NEXT_SHIFT,
    S_REL_PREV,
    S_PREV_SHIFT,
    S_DONE
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SCAN,
    OP_NOFIT,
    OP_FULL,
    OP_BADREL,
    OP_FREE,
    OP_SPLIT_INIT,
    OP_SHIFT_UP,
    OP_SPLIT_WR,
    OP_GRANT,
    OP_MNEXT,
    OP_MPREV,
    OP_SHIFT_DN,
    OP_DROP
  } op_t;

  typedef struct packed {
    logic scan_end;
    logic found;
    logic func;
    logic need_split;
    logic full;
    logic up_done;
    logic dn_done;
    logic nxt_free;
    logic prv_free;
  } dp_stat_t;

endpackage

// File: sv/fit_policy_block_allocator.sv
// Fit-policy block allocator: one 1024-byte arena split into up to 16
// contiguous blocks, each behind a 16-byte header, kept in address order.
// Request channel: in_func (0 allocate, 1 release), in_request_size and
// in_free_address; a request is taken on a clock edge with start high and
// busy low. One result per request: out_status and out_address are valid
// for the single cycle that out_strobe is high; there is no back-pressure,
// the receiver must take it then.
// Config: cfg_we with cfg_fit_policy writes the fit policy (first, next,
// best, worst); write only while busy is low.
// Flow: one request at a time. A request scans the table entries (up to
// the block count), takes a decide step, then moves the entries behind
// a block that is split or merged away, and ends with the strobe.
// Worst case is a release merging on both sides in a full table. busy
// drops in the cycle after the strobe, and a new request can be taken
// from then on.
// Reset (rst_n low, synchronous): one free block covering the whole
// arena, next-fit cursor at entry 0, first-fit policy, nothing busy.
module fit_policy_block_allocator (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic                    in_func,
  input  logic [fpba_pkg::AW-1:0] in_request_size,
  input  logic [fpba_pkg::AW-1:0] in_free_address,
  input  logic                    cfg_we,
  input  logic [1:0]              cfg_fit_policy,
  output logic                    out_strobe,
  output logic [1:0]              out_status,
  output logic [fpba_pkg::AW-1:0] out_address
);

  fpba_pkg::op_t      op;
  fpba_pkg::dp_stat_t stat;

  // sequencer: scan, decide, shift passes
  fpba_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .op    (op),
    .busy  (busy),
    .done  (out_strobe)
  );

  // block table, cursor, policy register and result registers
  fpba_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .op              (op),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_fit_policy),
    .in_func         (in_func),
    .in_request_size (in_request_size),
    .in_free_address (in_free_address),
    .stat            (stat),
    .res_status      (out_status),
    .res_address     (out_address)
  );

endmodule

// File: sv/fpba_ctrl.sv
module fpba_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  fpba_pkg::dp_stat_t stat,
  output fpba_pkg::op_t      op,
  output logic               busy,
  output logic               done
);

  fpba_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fpba_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fpba_pkg::S_IDLE:        if (start) state_nxt = fpba_pkg::S_SCAN;
      fpba_pkg::S_SCAN:        if (stat.scan_end) state_nxt = fpba_pkg::S_DECIDE;
      fpba_pkg::S_DECIDE: begin
        if (!stat.found) state_nxt = fpba_pkg::S_DONE;
        else if (stat.func == fpba_pkg::FUNC_RELEASE) state_nxt = fpba_pkg::S_REL_NEXT;
        else if (stat.need_split && !stat.full) state_nxt = fpba_pkg::S_SPLIT_SHIFT;
        else state_nxt = fpba_pkg::S_DONE;
      end
      fpba_pkg::S_SPLIT_SHIFT: if (stat.up_done) state_nxt = fpba_pkg::S_DONE;
      fpba_pkg::S_REL_NEXT:
        state_nxt = stat.nxt_free ? fpba_pkg::S_NEXT_SHIFT : fpba_pkg::S_REL_PREV;
      fpba_pkg::S_NEXT_SHIFT:  if (stat.dn_done) state_nxt = fpba_pkg::S_REL_PREV;
      fpba_pkg::S_REL_PREV:
        state_nxt = stat.prv_free ? fpba_pkg::S_PREV_SHIFT : fpba_pkg::S_DONE;
      fpba_pkg::S_PREV_SHIFT:  if (stat.dn_done) state_nxt = fpba_pkg::S_DONE;
      fpba_pkg::S_DONE:        state_nxt = fpba_pkg::S_IDLE;
      default:                 state_nxt = fpba_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    op   = fpba_pkg::OP_NONE;
    busy = (state_r != fpba_pkg::S_IDLE);
    done = (state_r == fpba_pkg::S_DONE);
    unique case (state_r)
      fpba_pkg::S_IDLE:        if (start) op = fpba_pkg::OP_LOAD;
      fpba_pkg::S_SCAN:        op = fpba_pkg::OP_SCAN;
      fpba_pkg::S_DECIDE: begin
        if (!stat.found)
          op = (stat.func == fpba_pkg::FUNC_RELEASE) ? fpba_pkg::OP_BADREL
                                                     : fpba_pkg::OP_NOFIT;
        else if (stat.func == fpba_pkg::FUNC_RELEASE) op = fpba_pkg::OP_FREE;
        else if (!stat.need_split) op = fpba_pkg::OP_GRANT;
        else if (stat.full) op = fpba_pkg::OP_FULL;
        else op = fpba_pkg::OP_SPLIT_INIT;
      end
      fpba_pkg::S_SPLIT_SHIFT:
        op = stat.up_done ? fpba_pkg::OP_SPLIT_WR : fpba_pkg::OP_SHIFT_UP;
      fpba_pkg::S_REL_NEXT:    if (stat.nxt_free) op = fpba_pkg::OP_MNEXT;
      fpba_pkg::S_NEXT_SHIFT,
      fpba_pkg::S_PREV_SHIFT:
        op = stat.dn_done ? fpba_pkg::OP_DROP : fpba_pkg::OP_SHIFT_DN;
      fpba_pkg::S_REL_PREV:    if (stat.prv_free) op = fpba_pkg::OP_MPREV;
      fpba_pkg::S_DONE:        op = fpba_pkg::OP_NONE;
      default:                 op = fpba_pkg::OP_NONE;
    endcase
  end

endmodule

// File: sv/fpba_dp.sv
module fpba_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  fpba_pkg::op_t              op,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_wdata,
  input  logic                       in_func,
  input  logic [fpba_pkg::AW-1:0]    in_request_size,
  input  logic [fpba_pkg::AW-1:0]    in_free_address,
  output fpba_pkg::dp_stat_t         stat,
  output logic [1:0]                 res_status,
  output logic [fpba_pkg::AW-1:0]    res_address
);

  localparam int AW = fpba_pkg::AW;
  localparam int IW = fpba_pkg::IW;
  localparam int CW = fpba_pkg::CW;
  localparam int NB = fpba_pkg::MaxBlocks;

  logic [AW-1:0] off_r  [NB];
  logic [AW-1:0] size_r [NB];
  logic [NB-1:0] used_r;
  logic [CW-1:0] count_r;
  logic [IW-1:0] cursor_r;
  logic [1:0]    policy_r;

  logic          func_r;
  logic [AW-1:0] req_r, fa_r;
  logic [IW-1:0] idx_r, pick_r, dropj_r;
  logic [CW-1:0] steps_r, k_r;
  logic          found_r;
  logic [AW-1:0] psize_r, poff_r;
  logic [1:0]    st_r;
  logic [AW-1:0] addr_r;

  logic [AW-1:0] cur_size, cur_off;
  logic          cur_used, fit, match, hit, take, stop;
  logic [IW-1:0] pick_p1, pick_m1, k_idx, k_m1, k_p1, idx_wrap, idx_init;

  assign cur_size = size_r[idx_r];
  assign cur_off  = off_r[idx_r];
  assign cur_used = used_r[idx_r];
  assign fit      = !cur_used && (cur_size >= req_r);
  assign match    = cur_used && ((cur_off + fpba_pkg::HDR) == fa_r);
  assign hit      = (func_r == fpba_pkg::FUNC_RELEASE) ? match : fit;
  assign stop     = hit && ((func_r == fpba_pkg::FUNC_RELEASE) ||
                            (policy_r == fpba_pkg::POL_FIRST) ||
                            (policy_r == fpba_pkg::POL_NEXT));
  assign take     = hit && (stop || !found_r ||
                            ((policy_r == fpba_pkg::POL_BEST)  && (cur_size < psize_r)) ||
                            ((policy_r == fpba_pkg::POL_WORST) && (cur_size > psize_r)));

  assign pick_p1  = pick_r + IW'(1);
  assign pick_m1  = pick_r - IW'(1);
  assign k_idx    = k_r[IW-1:0];
  assign k_m1     = k_idx - IW'(1);
  assign k_p1     = k_idx + IW'(1);
  assign idx_wrap = ((CW'(idx_r) + CW'(1)) == count_r) ? '0 : idx_r + IW'(1);
  // next fit starts at the cursor when it still names an entry
  assign idx_init = ((in_func == fpba_pkg::FUNC_ALLOC) &&
                     (policy_r == fpba_pkg::POL_NEXT) &&
                     (CW'(cursor_r) < count_r)) ? cursor_r : '0;

  always_comb begin
    stat.scan_end   = stop || ((steps_r + CW'(1)) >= count_r);
    stat.found      = found_r;
    stat.func       = func_r;
    stat.need_split = {1'b0, psize_r} > ({1'b0, req_r} + {1'b0, fpba_pkg::HDR});
    stat.full       = (count_r == fpba_pkg::FULL_CNT);
    stat.up_done    = (k_r <= (CW'(pick_r) + CW'(1)));
    stat.dn_done    = ((k_r + CW'(1)) >= count_r);
    stat.nxt_free   = ((CW'(pick_r) + CW'(1)) < count_r) && !used_r[pick_p1];
    stat.prv_free   = (pick_r != '0) && !used_r[pick_m1];
  end

  assign res_status  = st_r;
  assign res_address = addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= fpba_pkg::POL_FIRST;
    end else if (cfg_we) begin
      policy_r <= cfg_wdata;
    end
  end

  // block table and scan control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r[0]  <= '0;
      size_r[0] <= fpba_pkg::ROOT_SZ;
      used_r    <= '0;
      count_r   <= CW'(1);
      cursor_r  <= '0;
      found_r   <= 1'b0;
    end else begin
      case (op)
        fpba_pkg::OP_LOAD: begin
          func_r  <= in_func;
          req_r   <= in_request_size;
          fa_r    <= in_free_address;
          idx_r   <= idx_init;
          steps_r <= '0;
          found_r <= 1'b0;
        end
        fpba_pkg::OP_SCAN: begin
          if (take) begin
            found_r <= 1'b1;
            pick_r  <= idx_r;
            psize_r <= cur_size;
            poff_r  <= cur_off;
          end
          steps_r <= steps_r + CW'(1);
          idx_r   <= idx_wrap;
        end
        fpba_pkg::OP_NOFIT: begin
          st_r <= fpba_pkg::ST_NOFIT;  addr_r <= '0;
        end
        fpba_pkg::OP_FULL: begin
          st_r <= fpba_pkg::ST_FULL;   addr_r <= '0;
        end
        fpba_pkg::OP_BADREL: begin
          st_r <= fpba_pkg::ST_BADREL; addr_r <= '0;
        end
        fpba_pkg::OP_FREE: begin
          used_r[pick_r] <= 1'b0;
          st_r   <= fpba_pkg::ST_OK;
          addr_r <= '0;
        end
        fpba_pkg::OP_GRANT: begin
          used_r[pick_r] <= 1'b1;
          if (policy_r == fpba_pkg::POL_NEXT) cursor_r <= pick_r;
          st_r   <= fpba_pkg::ST_OK;
          addr_r <= poff_r + fpba_pkg::HDR;
        end
        fpba_pkg::OP_SPLIT_INIT: k_r <= count_r;
        fpba_pkg::OP_SHIFT_UP: begin
          off_r[k_idx]  <= off_r[k_m1];
          size_r[k_idx] <= size_r[k_m1];
          used_r[k_idx] <= used_r[k_m1];
          k_r <= k_r - CW'(1);
        end
        fpba_pkg::OP_SPLIT_WR: begin
          off_r[pick_p1]  <= poff_r + fpba_pkg::HDR + req_r;
          size_r[pick_p1] <= psize_r - req_r - fpba_pkg::HDR;
          used_r[pick_p1] <= 1'b0;
          size_r[pick_r]  <= req_r;
          used_r[pick_r]  <= 1'b1;
          count_r <= count_r + CW'(1);
          if (policy_r == fpba_pkg::POL_NEXT) cursor_r <= pick_p1;
          else if (cursor_r > pick_r) cursor_r <= cursor_r + IW'(1);
          st_r   <= fpba_pkg::ST_OK;
          addr_r <= poff_r + fpba_pkg::HDR;
        end
        fpba_pkg::OP_MNEXT: begin
          size_r[pick_r] <= size_r[pick_r] + size_r[pick_p1] + fpba_pkg::HDR;
          k_r     <= CW'(pick_r) + CW'(1);
          dropj_r <= pick_p1;
        end
        fpba_pkg::OP_MPREV: begin
          size_r[pick_m1] <= size_r[pick_m1] + size_r[pick_r] + fpba_pkg::HDR;
          k_r     <= CW'(pick_r);
          dropj_r <= pick_r;
        end
        fpba_pkg::OP_SHIFT_DN: begin
          off_r[k_idx]  <= off_r[k_p1];
          size_r[k_idx] <= size_r[k_p1];
          used_r[k_idx] <= used_r[k_p1];
          k_r <= k_r + CW'(1);
        end
        fpba_pkg::OP_DROP: begin
          count_r <= count_r - CW'(1);
          if (cursor_r >= dropj_r) cursor_r <= cursor_r - IW'(1);
        end
        default: ;
      endcase
    end
  end

endmodule
